>>> sv/nsrc_pkg.sv
// Shared types, widths and helpers for the nearest segment ray caster.
// No dependencies; every other file in sv/ refers to this package.
package nsrc_pkg;

    localparam int MAX_WALLS_DEF = 256;

    localparam int CO_W     = 20;
    localparam int DIR_W    = 16;
    localparam int RANGE_W  = 10;
    localparam int COUNT_W  = 9;
    localparam int INDEX_W  = 8;
    localparam int DIST_W   = 18;

    localparam int V_W      = CO_W + 1;
    localparam int AV_W     = CO_W;
    localparam int DIFF_W   = CO_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = PROD_W - 1;
    localparam int TD_W     = MAG_W + RANGE_W;
    localparam int TX_W     = MAG_W + AV_W;
    localparam int DIV_N_W  = TX_W + 1;
    localparam int DIV_D_W  = MAG_W + 1;
    localparam int QUO_W    = AV_W - 1;
    localparam int SETUP_W  = DIR_W + RANGE_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RANGE  = 1'b0,
        CFG_WALL_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_CAST = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                     mode;
        logic [INDEX_W-1:0]       wall_index;
        logic signed [CO_W-1:0]   wall_x1;
        logic signed [CO_W-1:0]   wall_y1;
        logic signed [CO_W-1:0]   wall_x2;
        logic signed [CO_W-1:0]   wall_y2;
        logic signed [CO_W-1:0]   origin_x;
        logic signed [CO_W-1:0]   origin_y;
        logic signed [DIR_W-1:0]  dir_x;
        logic signed [DIR_W-1:0]  dir_y;
    } in_t;

    typedef struct packed {
        logic                     hit;
        logic [DIST_W-1:0]        distance;
        logic signed [CO_W-1:0]   hit_x;
        logic signed [CO_W-1:0]   hit_y;
    } out_t;

    typedef struct packed {
        logic signed [CO_W-1:0] x1;
        logic signed [CO_W-1:0] y1;
        logic signed [CO_W-1:0] x2;
        logic signed [CO_W-1:0] y2;
    } wall_t;

    typedef struct packed {
        logic signed [CO_W-1:0] ox;
        logic signed [CO_W-1:0] oy;
        logic signed [V_W-1:0]  vx;
        logic signed [V_W-1:0]  vy;
        logic [AV_W-1:0]        ax;
        logic [AV_W-1:0]        ay;
        logic [RANGE_W-1:0]     r;
    } ray_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic ok;
    } tag_t;

    function automatic logic signed [CO_W-1:0] sat_co(input logic signed [V_W-1:0] v);
        logic signed [CO_W-1:0] res;
        if (v[V_W-1] != v[V_W-2]) begin
            res = v[V_W-1] ? {1'b1, {(CO_W-1){1'b0}}} : {1'b0, {(CO_W-1){1'b1}}};
        end else begin
            res = v[CO_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> sv/nsrc_wall_mem.sv
// Wall segment table: one write port, one registered read port.
// Depends on nsrc_pkg for the wall entry type.
module nsrc_wall_mem #(
    parameter int DEPTH = nsrc_pkg::MAX_WALLS_DEF
) (
    input  logic                                       aclk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  nsrc_pkg::wall_t                            wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output nsrc_pkg::wall_t                            rd_data
);

    nsrc_pkg::wall_t mem [DEPTH];
    nsrc_pkg::wall_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/nsrc_geom.sv
// Six-stage intersection front end: edge vectors, cross products, hit test,
// scaling products and divider numerators. Depends on nsrc_pkg.
module nsrc_geom (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  nsrc_pkg::ray_t                         ray,
    input  nsrc_pkg::wall_t                        wall_in,
    input  nsrc_pkg::tag_t                         tag_in,
    output logic [nsrc_pkg::DIV_N_W-1:0]           num_dist,
    output logic [nsrc_pkg::DIV_N_W-1:0]           num_x,
    output logic [nsrc_pkg::DIV_N_W-1:0]           num_y,
    output logic [nsrc_pkg::DIV_D_W-1:0]           div_den,
    output nsrc_pkg::tag_t                         tag_out
);

    localparam int DW = nsrc_pkg::DIFF_W;
    localparam int PW = nsrc_pkg::PROD_W;
    localparam int XW = nsrc_pkg::CROSS_W;
    localparam int MW = nsrc_pkg::MAG_W;
    localparam int NW = nsrc_pkg::DIV_N_W;
    localparam int DD = nsrc_pkg::DIV_D_W;

    nsrc_pkg::tag_t tag_a_reg, tag_b_reg, tag_c_reg, tag_d_reg, tag_e_reg, tag_f_reg;

    logic signed [DW-1:0] ex_reg, ey_reg, wx_reg, wy_reg;
    logic signed [DW-1:0] ex_next, ey_next, wx_next, wy_next;

    logic signed [PW-1:0] p_vxey_reg, p_vyex_reg, p_wyex_reg, p_wxey_reg, p_vxwy_reg, p_vywx_reg;

    logic signed [XW-1:0] den_reg, tn_reg, un_reg;

    logic signed [XW-1:0] den_n, tn_n, un_n;
    logic                 ok_next;
    logic [MW-1:0]        tn_mag_reg, den_mag_reg;

    logic [nsrc_pkg::TD_W-1:0] td_reg;
    logic [nsrc_pkg::TX_W-1:0] tx_reg, ty_reg;
    logic [MW-1:0]             den_e_reg;

    logic [NW-1:0] num_dist_reg, num_x_reg, num_y_reg;
    logic [DD-1:0] div_den_reg;

    always_comb begin
        ex_next = {wall_in.x2[nsrc_pkg::CO_W-1], wall_in.x2}
                - {wall_in.x1[nsrc_pkg::CO_W-1], wall_in.x1};
        ey_next = {wall_in.y2[nsrc_pkg::CO_W-1], wall_in.y2}
                - {wall_in.y1[nsrc_pkg::CO_W-1], wall_in.y1};
        wx_next = {ray.ox[nsrc_pkg::CO_W-1], ray.ox} - {wall_in.x1[nsrc_pkg::CO_W-1], wall_in.x1};
        wy_next = {ray.oy[nsrc_pkg::CO_W-1], ray.oy} - {wall_in.y1[nsrc_pkg::CO_W-1], wall_in.y1};
    end

    always_comb begin
        if (den_reg < 0) begin
            den_n = -den_reg;
            tn_n  = -tn_reg;
            un_n  = -un_reg;
        end else begin
            den_n = den_reg;
            tn_n  = tn_reg;
            un_n  = un_reg;
        end
        ok_next = (den_n != 0) && (tn_n >= 0) && (tn_n <= den_n)
                && (un_n >= 0) && (un_n <= den_n);
    end

    always_ff @(posedge aclk) begin
        ex_reg <= ex_next;
        ey_reg <= ey_next;
        wx_reg <= wx_next;
        wy_reg <= wy_next;

        p_vxey_reg <= PW'(ray.vx) * PW'(ey_reg);
        p_vyex_reg <= PW'(ray.vy) * PW'(ex_reg);
        p_wyex_reg <= PW'(wy_reg) * PW'(ex_reg);
        p_wxey_reg <= PW'(wx_reg) * PW'(ey_reg);
        p_vxwy_reg <= PW'(ray.vx) * PW'(wy_reg);
        p_vywx_reg <= PW'(ray.vy) * PW'(wx_reg);

        den_reg <= XW'(p_vxey_reg) - XW'(p_vyex_reg);
        tn_reg  <= XW'(p_wyex_reg) - XW'(p_wxey_reg);
        un_reg  <= XW'(p_vxwy_reg) - XW'(p_vywx_reg);

        tn_mag_reg  <= tn_n[MW-1:0];
        den_mag_reg <= den_n[MW-1:0];

        td_reg    <= nsrc_pkg::TD_W'(tn_mag_reg) * nsrc_pkg::TD_W'(ray.r);
        tx_reg    <= nsrc_pkg::TX_W'(tn_mag_reg) * nsrc_pkg::TX_W'(ray.ax);
        ty_reg    <= nsrc_pkg::TX_W'(tn_mag_reg) * nsrc_pkg::TX_W'(ray.ay);
        den_e_reg <= den_mag_reg;

        num_dist_reg <= NW'({td_reg, 9'b0}) + NW'(den_e_reg);
        num_x_reg    <= NW'({tx_reg, 1'b0}) + NW'(den_e_reg);
        num_y_reg    <= NW'({ty_reg, 1'b0}) + NW'(den_e_reg);
        div_den_reg  <= {den_e_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
            tag_e_reg <= '0;
            tag_f_reg <= '0;
        end else begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= '{valid: tag_c_reg.valid, last: tag_c_reg.last, ok: ok_next};
            tag_e_reg <= tag_d_reg;
            tag_f_reg <= tag_e_reg;
        end
    end

    assign num_dist = num_dist_reg;
    assign num_x    = num_x_reg;
    assign num_y    = num_y_reg;
    assign div_den  = div_den_reg;
    assign tag_out  = tag_f_reg;

endmodule

>>> sv/nsrc_div.sv
// Pipelined restoring divider, one quotient bit per stage, three numerators
// over a shared divisor. Depends on nsrc_pkg.
module nsrc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [nsrc_pkg::DIV_N_W-1:0]  num_dist,
    input  logic [nsrc_pkg::DIV_N_W-1:0]  num_x,
    input  logic [nsrc_pkg::DIV_N_W-1:0]  num_y,
    input  logic [nsrc_pkg::DIV_D_W-1:0]  den,
    input  nsrc_pkg::tag_t                tag_in,
    output logic [nsrc_pkg::QUO_W-1:0]    q_dist,
    output logic [nsrc_pkg::QUO_W-1:0]    q_x,
    output logic [nsrc_pkg::QUO_W-1:0]    q_y,
    output nsrc_pkg::tag_t                tag_out
);

    localparam int N = nsrc_pkg::DIV_N_W;
    localparam int D = nsrc_pkg::DIV_D_W;
    localparam int Q = nsrc_pkg::QUO_W;

    logic [N-1:0]   rd_reg [Q];
    logic [N-1:0]   rx_reg [Q];
    logic [N-1:0]   ry_reg [Q];
    logic [Q-1:0]   qd_reg [Q];
    logic [Q-1:0]   qx_reg [Q];
    logic [Q-1:0]   qy_reg [Q];
    logic [D-1:0]   dv_reg [Q];
    nsrc_pkg::tag_t tag_reg [Q];

    logic [N-1:0]   rd_in [Q];
    logic [N-1:0]   rx_in [Q];
    logic [N-1:0]   ry_in [Q];
    logic [Q-1:0]   qd_in [Q];
    logic [Q-1:0]   qx_in [Q];
    logic [Q-1:0]   qy_in [Q];
    logic [D-1:0]   dv_in [Q];
    nsrc_pkg::tag_t tag_in_s [Q];
    logic [N-1:0]   dsh [Q];
    logic           ge_d [Q];
    logic           ge_x [Q];
    logic           ge_y [Q];

    always_comb begin
        for (int s = 0; s < Q; s++) begin
            if (s == 0) begin
                rd_in[s]    = num_dist;
                rx_in[s]    = num_x;
                ry_in[s]    = num_y;
                qd_in[s]    = '0;
                qx_in[s]    = '0;
                qy_in[s]    = '0;
                dv_in[s]    = den;
                tag_in_s[s] = tag_in;
            end else begin
                rd_in[s]    = rd_reg[s-1];
                rx_in[s]    = rx_reg[s-1];
                ry_in[s]    = ry_reg[s-1];
                qd_in[s]    = qd_reg[s-1];
                qx_in[s]    = qx_reg[s-1];
                qy_in[s]    = qy_reg[s-1];
                dv_in[s]    = dv_reg[s-1];
                tag_in_s[s] = tag_reg[s-1];
            end
            dsh[s]  = N'(dv_in[s]) << (Q - 1 - s);
            ge_d[s] = rd_in[s] >= dsh[s];
            ge_x[s] = rx_in[s] >= dsh[s];
            ge_y[s] = ry_in[s] >= dsh[s];
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < Q; s++) begin
            rd_reg[s] <= ge_d[s] ? rd_in[s] - dsh[s] : rd_in[s];
            rx_reg[s] <= ge_x[s] ? rx_in[s] - dsh[s] : rx_in[s];
            ry_reg[s] <= ge_y[s] ? ry_in[s] - dsh[s] : ry_in[s];
            qd_reg[s] <= {qd_in[s][Q-2:0], ge_d[s]};
            qx_reg[s] <= {qx_in[s][Q-2:0], ge_x[s]};
            qy_reg[s] <= {qy_in[s][Q-2:0], ge_y[s]};
            dv_reg[s] <= dv_in[s];
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < Q; s++) begin
            if (!aresetn) begin
                tag_reg[s] <= '0;
            end else begin
                tag_reg[s] <= tag_in_s[s];
            end
        end
    end

    assign q_dist  = qd_reg[Q-1];
    assign q_x     = qx_reg[Q-1];
    assign q_y     = qy_reg[Q-1];
    assign tag_out = tag_reg[Q-1];

endmodule

>>> sv/nsrc_select.sv
// Nearest-hit tracker: keeps the smallest rounded distance of one ray and
// forms the result transaction. Depends on nsrc_pkg.
module nsrc_select (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        init,
    input  nsrc_pkg::ray_t              ray,
    input  nsrc_pkg::tag_t              tag,
    input  logic [nsrc_pkg::QUO_W-1:0]  q_dist,
    input  logic [nsrc_pkg::QUO_W-1:0]  q_x,
    input  logic [nsrc_pkg::QUO_W-1:0]  q_y,
    output nsrc_pkg::out_t              result,
    output logic                        done
);

    localparam int VW = nsrc_pkg::V_W;

    logic [nsrc_pkg::DIST_W-1:0]  best_reg;
    logic                         hit_reg;
    logic signed [nsrc_pkg::CO_W-1:0] bx_reg, by_reg;
    logic                         done_reg;

    logic [nsrc_pkg::DIST_W-1:0]  cand_dist;
    logic signed [VW-1:0]         off_x, off_y, sum_x, sum_y, end_x, end_y;
    logic                         take;

    always_comb begin
        cand_dist = q_dist[nsrc_pkg::DIST_W-1:0];
        off_x = ray.vx[VW-1] ? -VW'(q_x) : VW'(q_x);
        off_y = ray.vy[VW-1] ? -VW'(q_y) : VW'(q_y);
        sum_x = {ray.ox[nsrc_pkg::CO_W-1], ray.ox} + off_x;
        sum_y = {ray.oy[nsrc_pkg::CO_W-1], ray.oy} + off_y;
        end_x = {ray.ox[nsrc_pkg::CO_W-1], ray.ox} + ray.vx;
        end_y = {ray.oy[nsrc_pkg::CO_W-1], ray.oy} + ray.vy;
        take  = tag.valid && tag.ok && (cand_dist < best_reg);
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            best_reg <= {ray.r, 8'b0};
        end else if (take) begin
            best_reg <= cand_dist;
            bx_reg   <= nsrc_pkg::sat_co(sum_x);
            by_reg   <= nsrc_pkg::sat_co(sum_y);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= tag.valid && tag.last;
            if (init) begin
                hit_reg <= 1'b0;
            end else if (take) begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_comb begin
        result.hit      = hit_reg;
        result.distance = best_reg;
        result.hit_x    = hit_reg ? bx_reg : nsrc_pkg::sat_co(end_x);
        result.hit_y    = hit_reg ? by_reg : nsrc_pkg::sat_co(end_y);
    end

    assign done = done_reg;

endmodule

>>> sv/nearest_segment_ray_cast_top.sv
// Top level of the nearest segment ray caster: sequencer, setup, config.
// Depends on nsrc_pkg, nsrc_wall_mem, nsrc_geom, nsrc_div and nsrc_select.
//
// Input channel s_*: a transaction with mode load writes one wall entry;
// a transaction with mode cast runs one ray. A ray walks the first
// wall_count entries of the wall table (at most MAX_WALLS), one entry per
// cycle, into a 26-stage test pipeline (table read, six geometry stages,
// nineteen divider stages), then the nearest hit is picked. m_valid rises
// when that result is loaded into the output register (straight after
// setup when wall_count is 0), and the next ray can be accepted once it
// is loaded; the single table read port sets the one-wall-per-cycle pace.
// s_ready is high only while no ray is in flight.
// Output channel m_*: one transaction per ray, held in an output register.
// A new ray is accepted while a finished result waits; if the receiver
// still stalls at the end of that ray, the engine holds its result.
// Configuration cfg_*: always ready; write only while idle.
// Reset: synchronous, active low; max_range returns to 500, wall_count to 0.
// Wall entries are undefined until loaded.
module nearest_segment_ray_cast_top #(
    parameter int MAX_WALLS = nsrc_pkg::MAX_WALLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  nsrc_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output nsrc_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [nsrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nsrc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CW = $clog2(MAX_WALLS + 1);
    localparam int SW = nsrc_pkg::SETUP_W;

    nsrc_pkg::state_t state_reg, state_next;

    logic [nsrc_pkg::RANGE_W-1:0] max_range_reg;
    logic [nsrc_pkg::COUNT_W-1:0] wall_count_reg;

    nsrc_pkg::ray_t ray_reg;
    logic signed [nsrc_pkg::DIR_W-1:0] dx_reg, dy_reg;
    logic [CW-1:0] n_reg, idx_reg, n_next;
    nsrc_pkg::tag_t issue_tag_reg;

    logic m_valid_reg;
    nsrc_pkg::out_t m_data_reg;

    logic accept, accept_cast, wr_en, rd_en, init, load_out, idx_last;

    logic signed [SW-1:0] pdx, pdy;
    logic [SW-1:0] mag_x, mag_y;
    logic [nsrc_pkg::AV_W-1:0] ax_c, ay_c;

    nsrc_pkg::wall_t wall_wr;
    nsrc_pkg::wall_t wall_rd;
    logic [nsrc_pkg::DIV_N_W-1:0] num_dist, num_x, num_y;
    logic [nsrc_pkg::DIV_D_W-1:0] div_den;
    nsrc_pkg::tag_t geom_tag, div_tag;
    logic [nsrc_pkg::QUO_W-1:0] q_dist, q_x, q_y;
    nsrc_pkg::out_t result;
    logic done;

    assign accept      = s_valid && s_ready;
    assign accept_cast = accept && (s_data.mode == nsrc_pkg::MODE_CAST);
    assign wr_en       = accept && (s_data.mode == nsrc_pkg::MODE_LOAD)
                       && (32'(s_data.wall_index) < MAX_WALLS);
    assign idx_last    = idx_reg == (n_reg - CW'(1));
    assign wall_wr     = '{x1: s_data.wall_x1, y1: s_data.wall_y1,
                           x2: s_data.wall_x2, y2: s_data.wall_y2};

    always_comb begin
        s_ready  = state_reg == nsrc_pkg::ST_IDLE;
        rd_en    = state_reg == nsrc_pkg::ST_ISSUE;
        init     = state_reg == nsrc_pkg::ST_SETUP;
        load_out = (state_reg == nsrc_pkg::ST_FINISH) && (!m_valid_reg || m_ready);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nsrc_pkg::ST_IDLE: begin
                if (accept_cast) begin
                    state_next = nsrc_pkg::ST_SETUP;
                end
            end
            nsrc_pkg::ST_SETUP: begin
                state_next = (n_reg == '0) ? nsrc_pkg::ST_FINISH : nsrc_pkg::ST_ISSUE;
            end
            nsrc_pkg::ST_ISSUE: begin
                if (idx_last) begin
                    state_next = nsrc_pkg::ST_DRAIN;
                end
            end
            nsrc_pkg::ST_DRAIN: begin
                if (done) begin
                    state_next = nsrc_pkg::ST_FINISH;
                end
            end
            nsrc_pkg::ST_FINISH: begin
                if (load_out) begin
                    state_next = nsrc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nsrc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_next = (32'(wall_count_reg) > MAX_WALLS) ? CW'(MAX_WALLS) : CW'(wall_count_reg);
        pdx    = SW'(dx_reg) * $signed({{(SW - nsrc_pkg::RANGE_W){1'b0}}, ray_reg.r});
        pdy    = SW'(dy_reg) * $signed({{(SW - nsrc_pkg::RANGE_W){1'b0}}, ray_reg.r});
        mag_x  = pdx[SW-1] ? -pdx : pdx;
        mag_y  = pdy[SW-1] ? -pdy : pdy;
        ax_c   = nsrc_pkg::AV_W'((mag_x + SW'(32)) >> 6);
        ay_c   = nsrc_pkg::AV_W'((mag_y + SW'(32)) >> 6);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= nsrc_pkg::ST_IDLE;
            max_range_reg  <= nsrc_pkg::RANGE_RESET;
            wall_count_reg <= '0;
            issue_tag_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (nsrc_pkg::cfg_reg_t'(cfg_index))
                    nsrc_pkg::CFG_MAX_RANGE:  max_range_reg  <= cfg_data[nsrc_pkg::RANGE_W-1:0];
                    nsrc_pkg::CFG_WALL_COUNT: wall_count_reg <= cfg_data[nsrc_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            issue_tag_reg <= '{valid: rd_en, last: idx_last, ok: 1'b0};
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_cast) begin
            ray_reg.ox <= s_data.origin_x;
            ray_reg.oy <= s_data.origin_y;
            ray_reg.r  <= max_range_reg;
            dx_reg     <= s_data.dir_x;
            dy_reg     <= s_data.dir_y;
            n_reg      <= n_next;
        end
        if (init) begin
            ray_reg.ax <= ax_c;
            ray_reg.ay <= ay_c;
            ray_reg.vx <= pdx[SW-1] ? -nsrc_pkg::V_W'(ax_c) : nsrc_pkg::V_W'(ax_c);
            ray_reg.vy <= pdy[SW-1] ? -nsrc_pkg::V_W'(ay_c) : nsrc_pkg::V_W'(ay_c);
            idx_reg    <= '0;
        end else if (rd_en) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (load_out) begin
            m_data_reg <= result;
        end
    end

    nsrc_wall_mem #(
        .DEPTH(MAX_WALLS)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (AW'(s_data.wall_index)),
        .wr_data (wall_wr),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (wall_rd)
    );

    nsrc_geom u_geom (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ray      (ray_reg),
        .wall_in  (wall_rd),
        .tag_in   (issue_tag_reg),
        .num_dist (num_dist),
        .num_x    (num_x),
        .num_y    (num_y),
        .div_den  (div_den),
        .tag_out  (geom_tag)
    );

    nsrc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .num_dist (num_dist),
        .num_x    (num_x),
        .num_y    (num_y),
        .den      (div_den),
        .tag_in   (geom_tag),
        .q_dist   (q_dist),
        .q_x      (q_x),
        .q_y      (q_y),
        .tag_out  (div_tag)
    );

    nsrc_select u_select (
        .aclk    (aclk),
        .aresetn (aresetn),
        .init    (init),
        .ray     (ray_reg),
        .tag     (div_tag),
        .q_dist  (q_dist),
        .q_x     (q_x),
        .q_y     (q_y),
        .result  (result),
        .done    (done)
    );

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for nearest_segment_ray_cast_top: a scoreboard class
// mirrors wall loads and register writes, predicts ray casts, checks per field.
// Depends on nsrc_pkg and the RTL under sv/.
`timescale 1ns / 100ps

module tb_top;

    localparam int  TABLE_DEPTH = 256;
    localparam int  DRAIN_WAIT  = 320;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int  RANGE_W     = nsrc_pkg::RANGE_W;
    localparam int  COUNT_W     = nsrc_pkg::COUNT_W;
    localparam int  CFG_DATA_W  = nsrc_pkg::CFG_DATA_W;
    localparam int  CO_W        = nsrc_pkg::CO_W;
    localparam int  DIR_W       = nsrc_pkg::DIR_W;
    localparam int  INDEX_W     = nsrc_pkg::INDEX_W;
    localparam int  DIST_W      = nsrc_pkg::DIST_W;
    localparam int  IN_W        = $bits(nsrc_pkg::in_t);

    class ray_scoreboard;
        logic [RANGE_W-1:0] range_units;
        logic [COUNT_W-1:0] walls_tested;
        longint start_x[TABLE_DEPTH];
        longint start_y[TABLE_DEPTH];
        longint end_x[TABLE_DEPTH];
        longint end_y[TABLE_DEPTH];
        nsrc_pkg::out_t pending_hits[$];
        int     errors;

        function new();
            range_units  = nsrc_pkg::RANGE_RESET;
            walls_tested = '0;
            errors       = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                start_x[i] = 0; start_y[i] = 0; end_x[i] = 0; end_y[i] = 0;
            end
        endfunction

        function void write_reg(nsrc_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == nsrc_pkg::CFG_MAX_RANGE) begin
                range_units = val[RANGE_W-1:0];
            end else begin
                walls_tested = val[COUNT_W-1:0];
            end
        endfunction

        function longint round_div(longint num, longint den);
            if (num >= 0) return (num * 2 + den) / (den * 2);
            return -(((-num) * 2 + den) / (den * 2));
        endfunction

        function longint clip_co(longint v);
            if (v < -524288) return -524288;
            if (v > 524287) return 524287;
            return v;
        endfunction

        function void note_input(nsrc_pkg::in_t t);
            longint ox, oy, r, vx, vy, best, hx, hy, sx, sy, ex, ey, wx, wy;
            longint den, tn, un, cand;
            int     n;
            logic   hit;
            nsrc_pkg::out_t res;
            if (t.mode == nsrc_pkg::MODE_LOAD) begin
                start_x[t.wall_index] = longint'(t.wall_x1);
                start_y[t.wall_index] = longint'(t.wall_y1);
                end_x[t.wall_index]   = longint'(t.wall_x2);
                end_y[t.wall_index]   = longint'(t.wall_y2);
                return;
            end
            ox   = longint'(t.origin_x);
            oy   = longint'(t.origin_y);
            r    = longint'(range_units);
            vx   = round_div(longint'(t.dir_x) * r, 64);
            vy   = round_div(longint'(t.dir_y) * r, 64);
            best = r * 256;
            hit  = 1'b0;
            hx   = clip_co(ox + vx);
            hy   = clip_co(oy + vy);
            n    = (walls_tested > TABLE_DEPTH) ? TABLE_DEPTH : int'(walls_tested);
            for (int i = 0; i < n; i++) begin
                sx  = start_x[i];
                sy  = start_y[i];
                ex  = end_x[i] - sx;
                ey  = end_y[i] - sy;
                wx  = ox - sx;
                wy  = oy - sy;
                den = vx * ey - vy * ex;
                tn  = wy * ex - wx * ey;
                un  = vx * wy - vy * wx;
                if (den == 0) continue;
                if (den < 0) begin
                    den = -den; tn = -tn; un = -un;
                end
                if (tn < 0 || tn > den || un < 0 || un > den) continue;
                cand = round_div(tn * r * 256, den);
                if (cand < best) begin
                    best = cand;
                    hit  = 1'b1;
                    hx   = clip_co(ox + round_div(tn * vx, den));
                    hy   = clip_co(oy + round_div(tn * vy, den));
                end
            end
            res.hit      = hit;
            res.distance = best[DIST_W-1:0];
            res.hit_x    = hx[CO_W-1:0];
            res.hit_y    = hy[CO_W-1:0];
            pending_hits = {pending_hits, res};
        endfunction

        function void report(string field, longint want, longint got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        function void check(nsrc_pkg::out_t got);
            nsrc_pkg::out_t want;
            if (pending_hits.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_hits.pop_front();
            if (got.hit !== want.hit)
                report("hit", longint'(want.hit), longint'(got.hit));
            if (got.distance !== want.distance)
                report("distance", longint'(want.distance), longint'(got.distance));
            if (got.hit_x !== want.hit_x)
                report("hit_x", longint'(want.hit_x), longint'(got.hit_x));
            if (got.hit_y !== want.hit_y)
                report("hit_y", longint'(want.hit_y), longint'(got.hit_y));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    nsrc_pkg::in_t         s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    nsrc_pkg::out_t        m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [nsrc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ray_scoreboard sb = new();
    int     send_idle = 37;
    int     recv_idle = 77;
    longint cycles = 0;
    bit     loaded[TABLE_DEPTH];
    int     cur_range = 500;

    nearest_segment_ray_cast_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_data);
            if (m_valid && m_ready) sb.check(m_data);
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    function automatic int loaded_prefix();
        for (int i = 0; i < TABLE_DEPTH; i++) if (!loaded[i]) return i;
        return TABLE_DEPTH;
    endfunction

    task automatic send_item(nsrc_pkg::in_t t);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = t;
        if (t.mode == nsrc_pkg::MODE_LOAD) loaded[t.wall_index] = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending_hits.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    task automatic write_cfg(nsrc_pkg::cfg_reg_t idx, int val);
        logic [CFG_DATA_W-1:0] word;
        word = CFG_DATA_W'(val);
        if ($urandom_range(1)) begin
            if (idx == nsrc_pkg::CFG_MAX_RANGE)
                word[CFG_DATA_W-1:RANGE_W] = (CFG_DATA_W - RANGE_W)'($urandom);
            else
                word[CFG_DATA_W-1:COUNT_W] = (CFG_DATA_W - COUNT_W)'($urandom);
        end
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = word;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, word);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == nsrc_pkg::CFG_MAX_RANGE) cur_range = val;
    endtask

    function automatic nsrc_pkg::in_t noise_item();
        nsrc_pkg::in_t t;
        t = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        return t;
    endfunction

    function automatic int rand_co(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic nsrc_pkg::in_t make_wall(int idx, int x1, int y1, int x2, int y2);
        nsrc_pkg::in_t t;
        t = noise_item();
        t.mode = nsrc_pkg::MODE_LOAD; t.wall_index = INDEX_W'(idx);
        t.wall_x1 = CO_W'(x1); t.wall_y1 = CO_W'(y1);
        t.wall_x2 = CO_W'(x2); t.wall_y2 = CO_W'(y2);
        return t;
    endfunction

    function automatic nsrc_pkg::in_t make_ray(int ox, int oy, int dx, int dy);
        nsrc_pkg::in_t t;
        t = noise_item();
        t.mode = nsrc_pkg::MODE_CAST;
        t.origin_x = CO_W'(ox); t.origin_y = CO_W'(oy);
        t.dir_x = DIR_W'(dx); t.dir_y = DIR_W'(dy);
        return t;
    endfunction

    function automatic nsrc_pkg::in_t scene_item(int span, int max_idx);
        int  a, b;
        real m;
        if ($urandom_range(99) < 25)
            return make_wall(int'($urandom_range(max_idx)), rand_co(span), rand_co(span),
                             rand_co(span), rand_co(span));
        a = int'($urandom_range(32768)) - 16384;
        m = $sqrt(16384.0 * 16384.0 - real'(a) * real'(a));
        b = int'(m);
        if ($urandom_range(1)) b = -b;
        if ($urandom_range(1)) return make_ray(rand_co(span / 2), rand_co(span / 2), a, b);
        return make_ray(rand_co(span / 2), rand_co(span / 2), b, a);
    endfunction

    task automatic random_block(int items);
        int done, span, cnt, pre;
        done = 0;
        while (done < items) begin
            case ($urandom_range(9))
                0: write_cfg(nsrc_pkg::CFG_MAX_RANGE, 1023);
                1: write_cfg(nsrc_pkg::CFG_MAX_RANGE, int'($urandom_range(3)));
                default: write_cfg(nsrc_pkg::CFG_MAX_RANGE, int'($urandom_range(1, 1023)));
            endcase
            pre = loaded_prefix();
            cnt = ($urandom_range(9) == 0) ? pre
                                           : int'($urandom_range((pre < 16) ? pre : 16));
            write_cfg(nsrc_pkg::CFG_WALL_COUNT, cnt);
            span = (cur_range < 1) ? 256 : cur_range * 256;
            if (span > 524287) span = 524287;
            for (int k = 0; k < 40; k++) begin
                if ($urandom_range(99) < 8) send_item(noise_item());
                else send_item(scene_item(span, (cnt < 255) ? cnt : 255));
                done++;
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // wall ahead, parallel wall, duplicate wall (tie), degenerate point
        send_item(make_wall(0, 2560, -2560, 2560, 2560));
        send_item(make_wall(1, 0, 1280, 5120, 1280));
        send_item(make_wall(2, 2560, -2560, 2560, 2560));
        send_item(make_wall(3, 1000, 0, 1000, 0));
        send_item(make_wall(4, -524288, -524288, 524287, 524287));
        write_cfg(nsrc_pkg::CFG_WALL_COUNT, 5);
        send_item(make_ray(0, 0, 16384, 0));
        send_item(make_ray(0, 0, -16384, 0));
        send_item(make_ray(0, 0, 0, 16384));
        send_item(make_ray(0, -256, 32767, -32768));
        send_item(make_ray(524287, 524287, 16384, 16384));
        send_item(make_ray(-524288, -524288, -32768, -32768));
        send_item(make_ray(100, 100, 0, 0));
        write_cfg(nsrc_pkg::CFG_MAX_RANGE, 0);
        send_item(make_ray(300, -300, 16384, 0));
        write_cfg(nsrc_pkg::CFG_MAX_RANGE, 10);
        send_item(make_ray(0, 0, 16384, 0));
        write_cfg(nsrc_pkg::CFG_MAX_RANGE, 1023);
        send_item(make_ray(0, 0, 16384, 0));
        send_item(make_ray(-200000, 0, 16384, 0));
        write_cfg(nsrc_pkg::CFG_WALL_COUNT, 0);
        send_item(make_ray(0, 0, 16384, 0));

        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(make_wall(i, rand_co(200000), rand_co(200000),
                                rand_co(200000), rand_co(200000)));
        write_cfg(nsrc_pkg::CFG_WALL_COUNT, 256);
        for (int k = 0; k < 8; k++) send_item(scene_item(200000, 255));
        write_cfg(nsrc_pkg::CFG_WALL_COUNT, 511);
        for (int k = 0; k < 8; k++) send_item(scene_item(200000, 255));

        random_block(340);
        send_idle = 77; recv_idle = 37;
        random_block(340);
        send_idle = 0; recv_idle = 0;
        random_block(340);

        drain();
        if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/nsrc_pkg.sv
sv/nsrc_wall_mem.sv
sv/nsrc_geom.sv
sv/nsrc_div.sv
sv/nsrc_select.sv
sv/nearest_segment_ray_cast_top.sv
sim/tb_top.sv
